/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the flag-keeping ALU.
// Each macro samples on the rising edge of the module's clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_RUN(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ANY(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* rtl/cawf_pkg.sv */
// Types and constants of the flag-keeping ALU.
// Used by cawf_alu, cpu_alu_with_flags_top and the testbench; depends on nothing.
package cawf_pkg;

   localparam int REQ_DATA_WIDTH = 48;
   localparam int RSP_DATA_WIDTH = 40;

   typedef logic [4:0] opcode_type;

   localparam opcode_type OP_ADD   = 5'd0;
   localparam opcode_type OP_ADC   = 5'd1;
   localparam opcode_type OP_SUB   = 5'd2;
   localparam opcode_type OP_SBC   = 5'd3;
   localparam opcode_type OP_AND   = 5'd4;
   localparam opcode_type OP_XOR   = 5'd5;
   localparam opcode_type OP_OR    = 5'd6;
   localparam opcode_type OP_CP    = 5'd7;
   localparam opcode_type OP_INC   = 5'd8;
   localparam opcode_type OP_DEC   = 5'd9;
   localparam opcode_type OP_RLC   = 5'd10;
   localparam opcode_type OP_RRC   = 5'd11;
   localparam opcode_type OP_RL    = 5'd12;
   localparam opcode_type OP_RR    = 5'd13;
   localparam opcode_type OP_SLA   = 5'd14;
   localparam opcode_type OP_SRA   = 5'd15;
   localparam opcode_type OP_SWAP  = 5'd16;
   localparam opcode_type OP_SRL   = 5'd17;
   localparam opcode_type OP_BIT   = 5'd18;
   localparam opcode_type OP_RES   = 5'd19;
   localparam opcode_type OP_SET   = 5'd20;
   localparam opcode_type OP_RLCA  = 5'd21;
   localparam opcode_type OP_RRCA  = 5'd22;
   localparam opcode_type OP_RLA   = 5'd23;
   localparam opcode_type OP_RRA   = 5'd24;
   localparam opcode_type OP_DAA   = 5'd25;
   localparam opcode_type OP_CPL   = 5'd26;
   localparam opcode_type OP_SCF   = 5'd27;
   localparam opcode_type OP_CCF   = 5'd28;
   localparam opcode_type OP_ADD16 = 5'd29;
   localparam opcode_type OP_ADDSP = 5'd30;
   localparam opcode_type OP_LDA   = 5'd31;

   typedef struct packed {
      logic zero;
      logic subtract;
      logic hcarry;
      logic carry;
   } flags_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  operand;
      logic [2:0]  bit_index;
      logic [15:0] wide_base;
      logic [15:0] wide_addend;
   } req_type;

   typedef struct packed {
      logic [7:0]  byte_result;
      logic [15:0] wide_result;
      logic [7:0]  accumulator_out;
      flags_type   flags;
   } rsp_type;

endpackage

/* rtl/cawf_alu.sv */
// Combinational datapath of the flag-keeping ALU: one operation per call.
// Depends on cawf_pkg.
module cawf_alu (
   input  cawf_pkg::req_type   req,
   input  logic [7:0]          acc,
   input  cawf_pkg::flags_type flags,
   output cawf_pkg::rsp_type   rsp
);
   import cawf_pkg::*;

   // Rotate, shift or swap; returns the carry out above the byte.
   function automatic logic [8:0] shift_byte(input logic [2:0] sel, input logic [7:0] v,
                                             input logic cin);
      logic [8:0] r;
      case (sel)
         3'd0:    r = {v[7], v[6:0], v[7]};
         3'd1:    r = {v[0], v[0], v[7:1]};
         3'd2:    r = {v[7], v[6:0], cin};
         3'd3:    r = {v[0], cin, v[7:1]};
         3'd4:    r = {v[7], v[6:0], 1'b0};
         3'd5:    r = {v[0], v[7], v[7:1]};
         3'd6:    r = {1'b0, v[3:0], v[7:4]};
         default: r = {v[0], 1'b0, v[7:1]};
      endcase
      return r;
   endfunction

   logic [7:0]  d;
   logic        cc_add, cc_sub;
   logic [8:0]  sum9, dif9;
   logic [4:0]  hsum5, hdif5;
   logic [8:0]  cb_sh, acc_sh;
   logic [7:0]  inc8, dec8, bit_mask;
   logic        daa_hi, daa_lo;
   logic [7:0]  daa_up, daa_dn;
   logic [16:0] sum17;
   logic [12:0] hsum13;
   logic [15:0] off16;
   logic [4:0]  off_h5;
   logic [8:0]  off_c9;
   logic [7:0]  acc_new;
   flags_type   fl;

   assign d        = req.operand;
   assign cc_add   = (req.opcode == OP_ADC) & flags.carry;
   assign cc_sub   = (req.opcode == OP_SBC) & flags.carry;
   assign sum9     = {1'b0, acc} + {1'b0, d} + {8'd0, cc_add};
   assign hsum5    = {1'b0, acc[3:0]} + {1'b0, d[3:0]} + {4'd0, cc_add};
   assign dif9     = {1'b0, acc} - {1'b0, d} - {8'd0, cc_sub};
   assign hdif5    = {1'b0, acc[3:0]} - {1'b0, d[3:0]} - {4'd0, cc_sub};
   assign cb_sh    = shift_byte(3'(req.opcode - OP_RLC), d, flags.carry);
   assign acc_sh   = shift_byte(3'(req.opcode - OP_RLCA), acc, flags.carry);
   assign inc8     = d + 8'd1;
   assign dec8     = d - 8'd1;
   assign bit_mask = 8'd1 << req.bit_index;
   assign daa_hi   = flags.carry | (acc > 8'h99);
   assign daa_lo   = flags.hcarry | (acc[3:0] > 4'h9);
   assign daa_up   = acc + (daa_hi ? 8'h60 : 8'h00) + (daa_lo ? 8'h06 : 8'h00);
   assign daa_dn   = acc - (flags.carry ? 8'h60 : 8'h00) - (flags.hcarry ? 8'h06 : 8'h00);
   assign sum17    = {1'b0, req.wide_base} + {1'b0, req.wide_addend};
   assign hsum13   = {1'b0, req.wide_base[11:0]} + {1'b0, req.wide_addend[11:0]};
   assign off16    = req.wide_base + {{8{d[7]}}, d};
   assign off_h5   = {1'b0, req.wide_base[3:0]} + {1'b0, d[3:0]};
   assign off_c9   = {1'b0, req.wide_base[7:0]} + {1'b0, d};

   always_comb begin
      acc_new         = acc;
      fl              = flags;
      rsp.byte_result = acc;
      rsp.wide_result = 16'd0;
      unique case (req.opcode) inside
         OP_ADD, OP_ADC: begin
            acc_new = sum9[7:0];
            fl = '{zero: sum9[7:0] == 8'd0, subtract: 1'b0,
                   hcarry: hsum5[4], carry: sum9[8]};
            rsp.byte_result = acc_new;
         end
         OP_SUB, OP_SBC, OP_CP: begin
            if (req.opcode != OP_CP) begin
               acc_new = dif9[7:0];
            end
            fl = '{zero: dif9[7:0] == 8'd0, subtract: 1'b1,
                   hcarry: hdif5[4], carry: dif9[8]};
            rsp.byte_result = acc_new;
         end
         OP_AND: begin
            acc_new = acc & d;
            fl = '{zero: acc_new == 8'd0, subtract: 1'b0, hcarry: 1'b1, carry: 1'b0};
            rsp.byte_result = acc_new;
         end
         OP_XOR, OP_OR: begin
            acc_new = (req.opcode == OP_XOR) ? (acc ^ d) : (acc | d);
            fl = '{zero: acc_new == 8'd0, subtract: 1'b0, hcarry: 1'b0, carry: 1'b0};
            rsp.byte_result = acc_new;
         end
         OP_INC: begin
            fl.zero = inc8 == 8'd0;
            fl.subtract = 1'b0;
            fl.hcarry = d[3:0] == 4'hF;
            rsp.byte_result = inc8;
         end
         OP_DEC: begin
            fl.zero = dec8 == 8'd0;
            fl.subtract = 1'b1;
            fl.hcarry = d[3:0] == 4'h0;
            rsp.byte_result = dec8;
         end
         [OP_RLC:OP_SRL]: begin
            fl = '{zero: cb_sh[7:0] == 8'd0, subtract: 1'b0, hcarry: 1'b0,
                   carry: cb_sh[8]};
            rsp.byte_result = cb_sh[7:0];
         end
         OP_BIT: begin
            fl.zero = (d & bit_mask) == 8'd0;
            fl.subtract = 1'b0;
            fl.hcarry = 1'b1;
            rsp.byte_result = d;
         end
         OP_RES: rsp.byte_result = d & ~bit_mask;
         OP_SET: rsp.byte_result = d | bit_mask;
         [OP_RLCA:OP_RRA]: begin
            acc_new = acc_sh[7:0];
            fl = '{zero: 1'b0, subtract: 1'b0, hcarry: 1'b0, carry: acc_sh[8]};
            rsp.byte_result = acc_new;
         end
         OP_DAA: begin
            if (flags.subtract) begin
               acc_new = daa_dn;
            end else begin
               acc_new = daa_up;
               fl.carry = daa_hi;
            end
            fl.zero = acc_new == 8'd0;
            fl.hcarry = 1'b0;
            rsp.byte_result = acc_new;
         end
         OP_CPL: begin
            acc_new = ~acc;
            fl.subtract = 1'b1;
            fl.hcarry = 1'b1;
            rsp.byte_result = acc_new;
         end
         OP_SCF, OP_CCF: begin
            fl.subtract = 1'b0;
            fl.hcarry = 1'b0;
            fl.carry = (req.opcode == OP_SCF) ? 1'b1 : ~flags.carry;
         end
         OP_ADD16: begin
            fl.subtract = 1'b0;
            fl.hcarry = hsum13[12];
            fl.carry = sum17[16];
            rsp.wide_result = sum17[15:0];
         end
         OP_ADDSP: begin
            fl = '{zero: 1'b0, subtract: 1'b0, hcarry: off_h5[4], carry: off_c9[8]};
            rsp.wide_result = off16;
         end
         default: begin
            acc_new = d;
            rsp.byte_result = d;
         end
      endcase
      rsp.accumulator_out = acc_new;
      rsp.flags           = fl;
   end

endmodule

/* rtl/cpu_alu_with_flags_top.sv */
// Top level of the flag-keeping 8-bit ALU: input stage, datapath, result stage.
// Depends on cawf_pkg, cawf_alu and assert_macros.svh.
//
// Use: each transaction on the req_ channel carries one opcode with its operands.
// The block applies it to the accumulator and the Z, N, H and C flags it keeps,
// and returns exactly one transaction on the rsp_ channel, in order.
// A request taken into the input register is shown on rsp_ from the result register
// once that register is free. Throughput: one transaction per cycle while rsp_tready is high;
// the accumulator and flags written by one operation feed the next at once.
// The input register and the result register each hold one transaction, so a
// new request is taken while a finished result waits to be read.
// When the receiver holds rsp_tready low, the result stays, the input stage
// fills and req_tready then falls until the result is taken.
// Reset (synchronous, active high) empties both stages and clears the
// accumulator and all four flags.
`include "assert_macros.svh"

module cpu_alu_with_flags_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // opcode[4:0], operand[12:5], bit_index[15:13], wide_base[31:16],
   // wide_addend[47:32]
   input  logic [cawf_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // byte_result[7:0], wide_result[23:8], accumulator_out[31:24], zero_flag[32],
   // subtract_flag[33], hcarry_flag[34], carry_flag[35], zero fill[39:36]
   output logic [cawf_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import cawf_pkg::*;

   logic       stage_valid_ff, stage_valid_in;
   req_type    stage_ff, stage_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   logic [7:0] acc_ff;
   flags_type  flags_ff;
   rsp_type    alu_rsp;
   logic       out_free, advance;

   cawf_alu u_alu (
      .req   (stage_ff),
      .acc   (acc_ff),
      .flags (flags_ff),
      .rsp   (alu_rsp)
   );

   assign out_free   = ~out_valid_ff | rsp_tready;
   assign advance    = stage_valid_ff & out_free;
   assign req_tready = ~stage_valid_ff | out_free;

   always_comb begin
      stage_in.opcode      = req_tdata[4:0];
      stage_in.operand     = req_tdata[12:5];
      stage_in.bit_index   = req_tdata[15:13];
      stage_in.wide_base   = req_tdata[31:16];
      stage_in.wide_addend = req_tdata[47:32];
      stage_valid_in       = (req_tvalid & req_tready) | (stage_valid_ff & ~out_free);
      out_valid_in         = advance | (out_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         acc_ff         <= 8'd0;
         flags_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         if (advance) begin
            acc_ff   <= alu_rsp.accumulator_out;
            flags_ff <= alu_rsp.flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_ff <= stage_in;
      end
      if (advance) begin
         out_ff <= alu_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.flags.carry, out_ff.flags.hcarry,
                        out_ff.flags.subtract, out_ff.flags.zero,
                        out_ff.accumulator_out, out_ff.wide_result, out_ff.byte_result};

   `ASSERT_RUN(a_state_matches_rsp, rsp_tvalid |-> (acc_ff == out_ff.accumulator_out && flags_ff == out_ff.flags), "Kept state differs from the pending result.")
   `ASSERT_RUN(a_state_holds_on_stall, (out_valid_ff && !rsp_tready) |=> ($stable(acc_ff) && $stable(flags_ff)), "State changed while the result was stalled.")
   `ASSERT_RUN(a_busy_means_full, !req_tready |-> (stage_valid_ff && out_valid_ff), "Input held off with a free stage.")
   `ASSERT_ANY(a_empty_after_reset, reset |=> (!rsp_tvalid && req_tready), "Stages not empty after reset.")

endmodule

/* tb/tb_cpu_alu_with_flags_top.sv */
// Self-checking testbench for cpu_alu_with_flags_top: directed table then random opcodes,
// with random idle and stall gaps on both stream channels and an in-order result check.
// Depends on cawf_pkg and the cpu_alu_with_flags_top RTL.
`timescale 1ns / 1ps

module tb_cpu_alu_with_flags_top;
   import cawf_pkg::*;

   localparam int CLOCK_PERIOD    = 12;
   localparam int RESET_CYCLES    = 12;
   localparam int RANDOM_ITEMS    = 900;
   localparam int DRAIN_CYCLES    = 8;
   localparam int DIRECTED_COUNT  = 38;
   localparam longint TIMEOUT_NS  = 64'd6_000_000;

   typedef struct {
      logic [7:0]  byte_result;
      logic [15:0] wide_result;
      logic [7:0]  accumulator_out;
      logic [3:0]  flags;          // {zero, subtract, hcarry, carry}
   } alu_result_t;

   typedef struct {
      opcode_type  op;
      logic [7:0]  operand;
      logic [2:0]  bit_index;
      logic [15:0] wide_base;
      logic [15:0] wide_addend;
      bit          known;
      alu_result_t result;
   } dir_row_t;

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   logic [7:0]  acc_model   = 8'h00;
   logic [3:0]  flags_model = 4'b0000;
   alu_result_t pending_results [$];
   alu_result_t no_result;
   int          error_count    = 0;
   bit          sender_quiet   = 1'b0;
   bit          receiver_quiet = 1'b0;

   dir_row_t directed_rows [0:DIRECTED_COUNT-1] = '{
      '{OP_LDA,   8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b1, '{8'hFF, 16'h0000, 8'hFF, 4'b0000}},
      '{OP_ADD,   8'h01, 3'd0, 16'h0000, 16'h0000, 1'b1, '{8'h00, 16'h0000, 8'h00, 4'b1011}},
      '{OP_ADC,   8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b1, '{8'h00, 16'h0000, 8'h00, 4'b1011}},
      '{OP_SUB,   8'h01, 3'd0, 16'h0000, 16'h0000, 1'b1, '{8'hFF, 16'h0000, 8'hFF, 4'b0111}},
      '{OP_SBC,   8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b1, '{8'hFF, 16'h0000, 8'hFF, 4'b0111}},
      '{OP_CP,    8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b1, '{8'hFF, 16'h0000, 8'hFF, 4'b1100}},
      '{OP_AND,   8'h00, 3'd0, 16'h0000, 16'h0000, 1'b1, '{8'h00, 16'h0000, 8'h00, 4'b1010}},
      '{OP_XOR,   8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b1, '{8'hFF, 16'h0000, 8'hFF, 4'b0000}},
      '{OP_OR,    8'h00, 3'd0, 16'h0000, 16'h0000, 1'b1, '{8'hFF, 16'h0000, 8'hFF, 4'b0000}},
      '{OP_INC,   8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_DEC,   8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_RLC,   8'h80, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_RRC,   8'h01, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_RL,    8'h80, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_RR,    8'h01, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_SLA,   8'h80, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_SRA,   8'h81, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_SWAP,  8'hF0, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_SRL,   8'h01, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_BIT,   8'h7F, 3'd7, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_RES,   8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_SET,   8'h00, 3'd7, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_LDA,   8'h80, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_RLCA,  8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_RRCA,  8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_RLA,   8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_RRA,   8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_LDA,   8'h9A, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_ADD,   8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_DAA,   8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_SUB,   8'h01, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_DAA,   8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_CPL,   8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_SCF,   8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_CCF,   8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_ADD16, 8'h00, 3'd0, 16'hFFFF, 16'h0001, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_ADDSP, 8'h80, 3'd0, 16'hFFFF, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}},
      '{OP_ADDSP, 8'h01, 3'd0, 16'h00FF, 16'h0000, 1'b0, '{8'h00, 16'h0000, 8'h00, 4'b0000}}
   };

   cpu_alu_with_flags_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [7:0] shift_byte(input opcode_type kind, input logic [7:0] v,
                                             input logic cin, output logic cout);
      case (kind)
         OP_RLC: begin
            cout = v[7];
            shift_byte = {v[6:0], v[7]};
         end
         OP_RRC: begin
            cout = v[0];
            shift_byte = {v[0], v[7:1]};
         end
         OP_RL: begin
            cout = v[7];
            shift_byte = {v[6:0], cin};
         end
         OP_RR: begin
            cout = v[0];
            shift_byte = {cin, v[7:1]};
         end
         OP_SLA: begin
            cout = v[7];
            shift_byte = {v[6:0], 1'b0};
         end
         OP_SRA: begin
            cout = v[0];
            shift_byte = {v[7], v[7:1]};
         end
         OP_SWAP: begin
            cout = 1'b0;
            shift_byte = {v[3:0], v[7:4]};
         end
         default: begin
            cout = v[0];
            shift_byte = {1'b0, v[7:1]};
         end
      endcase
   endfunction

   // Applies one operation to the accumulator and flag copies and returns its result.
   function automatic alu_result_t predict_alu(input opcode_type op, input logic [7:0] d,
                                               input logic [2:0] bi, input logic [15:0] base,
                                               input logic [15:0] addend);
      alu_result_t r;
      logic [7:0]  a;
      logic [7:0]  res;
      logic [15:0] wide;
      logic        z, n, h, c, cc, cout;
      logic [8:0]  sum9;
      logic [4:0]  lo5;
      logic [12:0] lo13;
      logic [16:0] sum17;
      opcode_type  cb_kind;
      a = acc_model;
      {z, n, h, c} = flags_model;
      res = a;
      wide = 16'h0000;
      case (op)
         OP_ADD, OP_ADC: begin
            cc = (op == OP_ADC) ? c : 1'b0;
            sum9 = {1'b0, a} + {1'b0, d} + {8'h00, cc};
            lo5 = {1'b0, a[3:0]} + {1'b0, d[3:0]} + {4'h0, cc};
            h = lo5[4];
            c = sum9[8];
            a = sum9[7:0];
            z = (a == 8'h00);
            n = 1'b0;
            res = a;
         end
         OP_SUB, OP_SBC, OP_CP: begin
            cc = (op == OP_SBC) ? c : 1'b0;
            sum9 = {1'b0, a} - {1'b0, d} - {8'h00, cc};
            lo5 = {1'b0, a[3:0]} - {1'b0, d[3:0]} - {4'h0, cc};
            h = lo5[4];
            c = sum9[8];
            z = (sum9[7:0] == 8'h00);
            n = 1'b1;
            if (op != OP_CP) a = sum9[7:0];
            res = a;
         end
         OP_AND: begin
            a = a & d;
            {z, n, h, c} = {a == 8'h00, 1'b0, 1'b1, 1'b0};
            res = a;
         end
         OP_XOR: begin
            a = a ^ d;
            {z, n, h, c} = {a == 8'h00, 1'b0, 1'b0, 1'b0};
            res = a;
         end
         OP_OR: begin
            a = a | d;
            {z, n, h, c} = {a == 8'h00, 1'b0, 1'b0, 1'b0};
            res = a;
         end
         OP_INC: begin
            h = (d[3:0] == 4'hF);
            res = d + 8'd1;
            z = (res == 8'h00);
            n = 1'b0;
         end
         OP_DEC: begin
            h = (d[3:0] == 4'h0);
            res = d - 8'd1;
            z = (res == 8'h00);
            n = 1'b1;
         end
         OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
            res = shift_byte(op, d, c, cout);
            {z, n, h, c} = {res == 8'h00, 1'b0, 1'b0, cout};
         end
         OP_BIT: begin
            z = ~d[bi];
            n = 1'b0;
            h = 1'b1;
            res = d;
         end
         OP_RES: res = d & ~(8'd1 << bi);
         OP_SET: res = d | (8'd1 << bi);
         OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
            cb_kind = op - (OP_RLCA - OP_RLC);
            a = shift_byte(cb_kind, a, c, cout);
            {z, n, h, c} = {1'b0, 1'b0, 1'b0, cout};
            res = a;
         end
         OP_DAA: begin
            if (!n) begin
               if (c || a > 8'h99) begin
                  a = a + 8'h60;
                  c = 1'b1;
               end
               if (h || a[3:0] > 4'h9) a = a + 8'h06;
            end else begin
               if (c) a = a - 8'h60;
               if (h) a = a - 8'h06;
            end
            z = (a == 8'h00);
            h = 1'b0;
            res = a;
         end
         OP_CPL: begin
            a = ~a;
            n = 1'b1;
            h = 1'b1;
            res = a;
         end
         OP_SCF: {n, h, c} = {1'b0, 1'b0, 1'b1};
         OP_CCF: {n, h, c} = {1'b0, 1'b0, ~c};
         OP_ADD16: begin
            sum17 = {1'b0, base} + {1'b0, addend};
            lo13 = {1'b0, base[11:0]} + {1'b0, addend[11:0]};
            h = lo13[12];
            c = sum17[16];
            n = 1'b0;
            wide = sum17[15:0];
         end
         OP_ADDSP: begin
            wide = base + {{8{d[7]}}, d};
            lo5 = {1'b0, base[3:0]} + {1'b0, d[3:0]};
            sum9 = {1'b0, base[7:0]} + {1'b0, d};
            h = lo5[4];
            c = sum9[8];
            z = 1'b0;
            n = 1'b0;
         end
         default: begin
            a = d;
            res = a;
         end
      endcase
      acc_model = a;
      flags_model = {z, n, h, c};
      r.byte_result = res;
      r.wide_result = wide;
      r.accumulator_out = a;
      r.flags = flags_model;
      return r;
   endfunction

   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 19))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 19))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h0FFF;
         3: return 16'h00FF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_request(input opcode_type op, input logic [7:0] d, input logic [2:0] bi,
                               input logic [15:0] base, input logic [15:0] addend,
                               input bit known, input alu_result_t typed_result);
      int          gap;
      logic        ready_seen;
      alu_result_t predicted;
      gap = pick_gap(sender_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {addend, base, bi, d, op};
      do begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
      end while (!ready_seen);
      predicted = predict_alu(op, d, bi, base, addend);
      pending_results.push_back(known ? typed_result : predicted);
   endtask

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result(input logic [RSP_DATA_WIDTH-1:0] data);
      alu_result_t want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result transaction, actual 0x%0h", $time, data);
         error_count++;
      end else begin
         want = pending_results.pop_front();
         report_field("byte_result", 32'(want.byte_result), 32'(data[7:0]));
         report_field("wide_result", 32'(want.wide_result), 32'(data[23:8]));
         report_field("accumulator_out", 32'(want.accumulator_out), 32'(data[31:24]));
         report_field("zero_flag", 32'(want.flags[3]), 32'(data[32]));
         report_field("subtract_flag", 32'(want.flags[2]), 32'(data[33]));
         report_field("hcarry_flag", 32'(want.flags[1]), 32'(data[34]));
         report_field("carry_flag", 32'(want.flags[0]), 32'(data[35]));
      end
   endtask

   initial begin : result_ready
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if ($urandom_range(0, 149) == 0) receiver_quiet = !receiver_quiet;
            if (stall_left > 0) begin
               rsp_tready <= 1'b0;
               stall_left--;
            end else begin
               rsp_tready <= 1'b1;
               stall_left = pick_gap(receiver_quiet);
            end
         end
      end
   end

   initial begin : result_monitor
      forever begin
         @(negedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_result(rsp_tdata);
      end
   end

   initial begin : stimulus
      opcode_type op;
      no_result = '{8'h00, 16'h0000, 8'h00, 4'b0000};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_request(directed_rows[i].op, directed_rows[i].operand, directed_rows[i].bit_index,
                      directed_rows[i].wide_base, directed_rows[i].wide_addend,
                      directed_rows[i].known, directed_rows[i].result);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 59) == 0) sender_quiet = !sender_quiet;
         op = ($urandom_range(0, 9) == 0) ? OP_DAA : opcode_type'($urandom_range(0, 31));
         send_request(op, rand_byte(), 3'($urandom_range(0, 7)), rand_word(), rand_word(),
                      1'b0, no_result);
      end
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
